// ----- rtl/mbdt_pkg.sv -----
// Shared constants, codes and types of the memory bus with DMA, timer and interrupt flags.
`default_nettype none

package mbdt_pkg;

    // Storage sizes. ROM_DEPTH must be a power of two: the ROM is mirrored by masking.
    localparam int RAM_DEPTH  = 32768;
    localparam int ROM_DEPTH  = 32768;
    localparam int DMA_LENGTH = 160;

    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int ROM_AW = $clog2(ROM_DEPTH);
    localparam int DMA_CW = $clog2(DMA_LENGTH + 1);

    // Address map
    localparam logic [15:0] RAM_BASE    = 16'h8000;
    localparam logic [15:0] ADDR_JOYPAD = 16'hFF00;
    localparam logic [15:0] ADDR_DIV    = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA   = 16'hFF05;
    localparam logic [15:0] ADDR_TMA    = 16'hFF06;
    localparam logic [15:0] ADDR_IF     = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA    = 16'hFF46;
    localparam logic [15:0] OAM_BASE    = 16'hFE00;

    // Transaction kinds
    localparam logic [2:0] KIND_READ       = 3'd0;
    localparam logic [2:0] KIND_WRITE      = 3'd1;
    localparam logic [2:0] KIND_ROM_LOAD   = 3'd2;
    localparam logic [2:0] KIND_DIV_TICK   = 3'd3;
    localparam logic [2:0] KIND_TIMER_TICK = 3'd4;
    localparam logic [2:0] KIND_IRQ_SET    = 3'd5;
    localparam logic [2:0] KIND_IRQ_CLEAR  = 3'd6;

    // Joypad select field (bits 5:4 of the joypad register)
    localparam logic [1:0] JOY_SEL_NONE    = 2'b11;
    localparam logic [1:0] JOY_SEL_DPAD    = 2'b10;
    localparam logic [1:0] JOY_SEL_BUTTONS = 2'b01;
    localparam logic [1:0] JOY_SEL_ALL     = 2'b00;

    localparam logic [7:0] JOY_IDLE_VALUE = 8'h3F;
    localparam logic [7:0] IF_TIMER_MASK  = 8'h04;
    localparam logic [7:0] BYTE_MAX       = 8'hFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [2:0]  interrupt_bit;
        logic [7:0]  dpad_lines;
        logic [7:0]  button_lines;
    } t_item;

endpackage

`default_nettype wire

// ----- rtl/mbdt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port (read-first).
`default_nettype none

module mbdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ----- rtl/memory_bus_with_dma_timer_irq.sv -----
// Top level of the byte bus: cartridge ROM, work RAM, joypad, OAM DMA, DIV, timer and IF.
`default_nettype none

// One transaction goes in, one comes out. After reset the block holds o_stall high while
// it sweeps the work RAM to zero, one entry a cycle. From then on a transaction is taken
// every cycle while the result side does not stall: it is registered in the execute slot,
// its RAM or ROM read issues at the accept edge, and its result is loaded into the output
// register when it retires, so a new transaction can be accepted while the previous
// result still waits. A write to the DMA register (0xFF46) is the exception: its result
// comes out at once, but the input side is held while the copy engine moves DMA_LENGTH
// bytes, one a cycle, reading over the bus and writing through the single write port of
// the work RAM. Joypad, DIV, TIMA, TMA and IF live in flip-flops and shadow their RAM
// addresses; all other state sits in two synchronous memories (work RAM, cartridge ROM).
// A write that lands in the cycle the next transaction reads the same entry is forwarded.

module memory_bus_with_dma_timer_irq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [2:0]  i_interrupt_bit,
    input  wire logic [7:0]  i_dpad_lines,
    input  wire logic [7:0]  i_button_lines,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [7:0]  o_read_data,
    output logic      [7:0]  o_interrupt_flags
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DMA   = 2'd2;

    localparam int RAM_AW = mbdt_pkg::RAM_AW;
    localparam int ROM_AW = mbdt_pkg::ROM_AW;
    localparam int DMA_CW = mbdt_pkg::DMA_CW;

    // control
    logic [1:0]          r_state;
    logic [RAM_AW-1:0]   r_clr;
    logic                r_exec_valid;
    mbdt_pkg::t_item     r_item;
    logic                r_out_valid;
    logic [7:0]          r_out_rd;
    logic [7:0]          r_out_if;

    // shadowed special registers
    logic [7:0] r_joy, r_div, r_tima, r_tma, r_if;
    logic [7:0] n_joy, n_div, n_tima, n_tma, n_if;

    // forwarding of the last transaction's memory write
    logic              r_wfwd_valid;
    logic [RAM_AW-1:0] r_wfwd_idx;
    logic [7:0]        r_wfwd_data;
    logic              r_rfwd_valid;
    logic [ROM_AW-1:0] r_rfwd_idx;
    logic [7:0]        r_rfwd_data;

    // DMA engine
    logic [DMA_CW-1:0] r_dma_cnt;
    logic              r_dma_dv;
    logic [7:0]        r_dma_idx;
    logic [15:0]       r_dma_src;

    // handshake and decode
    logic        accept, exec_fire, exec_is_dma, dma_issue;
    logic [15:0] dma_src_next, dma_dst, sel_addr;
    logic [7:0]  rom_q, ram_q, rom_byte, ram_byte, joy_byte, bus_byte, n_rd;
    logic        ram_we_item, rom_we_item;

    // memory ports
    logic              wram_we, wram_re, rom_we;
    logic [RAM_AW-1:0] wram_waddr, wram_raddr;
    logic [7:0]        wram_wdata;
    logic [ROM_AW-1:0] rom_raddr;

    // ------------------------------------------------------------------
    // Handshake: take a transaction in RUN once the execute slot frees up.
    // ------------------------------------------------------------------
    assign exec_fire   = r_exec_valid && (!r_out_valid || !i_stall);
    assign exec_is_dma = (r_item.kind == mbdt_pkg::KIND_WRITE)
                      && (r_item.address == mbdt_pkg::ADDR_DMA);
    assign o_stall     = !((r_state == ST_RUN)
                        && (!r_exec_valid || (exec_fire && !exec_is_dma)));
    assign accept      = i_valid && !o_stall;

    // DMA source and destination: page and index fit in one byte each
    assign dma_issue    = (r_state == ST_DMA) && (r_dma_cnt < DMA_CW'(mbdt_pkg::DMA_LENGTH));
    assign dma_src_next = {r_item.write_data, 8'(r_dma_cnt)};
    assign dma_dst      = mbdt_pkg::OAM_BASE + {8'h00, r_dma_idx};

    // ------------------------------------------------------------------
    // Bus read decode, shared by read transactions and DMA source reads.
    // ------------------------------------------------------------------
    assign sel_addr = (r_state == ST_DMA) ? r_dma_src : r_item.address;

    assign rom_byte = ((r_state == ST_RUN) && r_rfwd_valid
                       && (r_rfwd_idx == sel_addr[ROM_AW-1:0])) ? r_rfwd_data : rom_q;
    assign ram_byte = ((r_state == ST_RUN) && r_wfwd_valid
                       && (r_wfwd_idx == sel_addr[RAM_AW-1:0])) ? r_wfwd_data : ram_q;

    always_comb begin
        case (r_joy[5:4])
            mbdt_pkg::JOY_SEL_NONE:    joy_byte = mbdt_pkg::JOY_IDLE_VALUE;
            mbdt_pkg::JOY_SEL_DPAD:    joy_byte = r_joy | r_item.dpad_lines;
            mbdt_pkg::JOY_SEL_BUTTONS: joy_byte = r_joy | r_item.button_lines;
            mbdt_pkg::JOY_SEL_ALL:     joy_byte = r_joy;
            default:                   joy_byte = r_joy;
        endcase
    end

    always_comb begin
        if (sel_addr < mbdt_pkg::RAM_BASE) begin
            bus_byte = rom_byte;
        end else begin
            case (sel_addr)
                mbdt_pkg::ADDR_JOYPAD: bus_byte = joy_byte;
                mbdt_pkg::ADDR_DIV:    bus_byte = r_div;
                mbdt_pkg::ADDR_TIMA:   bus_byte = r_tima;
                mbdt_pkg::ADDR_TMA:    bus_byte = r_tma;
                mbdt_pkg::ADDR_IF:     bus_byte = r_if;
                default:               bus_byte = ram_byte;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Execute: work out the new special registers and any memory write.
    // ------------------------------------------------------------------
    always_comb begin
        n_joy       = r_joy;
        n_div       = r_div;
        n_tima      = r_tima;
        n_tma       = r_tma;
        n_if        = r_if;
        n_rd        = 8'h00;
        ram_we_item = 1'b0;
        rom_we_item = 1'b0;
        case (r_item.kind)
            mbdt_pkg::KIND_READ: begin
                n_rd = bus_byte;
            end
            mbdt_pkg::KIND_WRITE: begin
                // writes into ROM space are dropped
                if (r_item.address >= mbdt_pkg::RAM_BASE) begin
                    case (r_item.address)
                        mbdt_pkg::ADDR_JOYPAD: n_joy  = r_item.write_data;
                        mbdt_pkg::ADDR_DIV:    n_div  = 8'h00;
                        mbdt_pkg::ADDR_TIMA:   n_tima = r_item.write_data;
                        mbdt_pkg::ADDR_TMA:    n_tma  = r_item.write_data;
                        mbdt_pkg::ADDR_IF:     n_if   = r_item.write_data;
                        mbdt_pkg::ADDR_DMA:    ram_we_item = 1'b0;  // copy engine takes over
                        default:               ram_we_item = 1'b1;
                    endcase
                end
            end
            mbdt_pkg::KIND_ROM_LOAD: begin
                rom_we_item = (r_item.address < mbdt_pkg::RAM_BASE);
            end
            mbdt_pkg::KIND_DIV_TICK: begin
                n_div = 8'(r_div + 8'd1);
            end
            mbdt_pkg::KIND_TIMER_TICK: begin
                // overflow: reload from TMA and raise the timer request
                if (r_tima == mbdt_pkg::BYTE_MAX) begin
                    n_tima = r_tma;
                    n_if   = r_if | mbdt_pkg::IF_TIMER_MASK;
                end else begin
                    n_tima = 8'(r_tima + 8'd1);
                end
            end
            mbdt_pkg::KIND_IRQ_SET: begin
                n_if = r_if | (8'h01 << r_item.interrupt_bit);
            end
            mbdt_pkg::KIND_IRQ_CLEAR: begin
                n_if = r_if & ~(8'h01 << r_item.interrupt_bit);
            end
            default: begin
                n_rd = 8'h00;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory ports: clearing sweep, DMA copy or transaction write.
    // ------------------------------------------------------------------
    always_comb begin
        wram_we    = 1'b0;
        wram_waddr = r_item.address[RAM_AW-1:0];
        wram_wdata = r_item.write_data;
        if (r_state == ST_CLEAR) begin
            wram_we    = 1'b1;
            wram_waddr = r_clr;
            wram_wdata = 8'h00;
        end else if ((r_state == ST_DMA) && r_dma_dv) begin
            wram_we    = 1'b1;
            wram_waddr = dma_dst[RAM_AW-1:0];
            wram_wdata = bus_byte;
        end else if (exec_fire && ram_we_item) begin
            wram_we    = 1'b1;
        end
    end

    assign wram_re    = accept || dma_issue;
    assign wram_raddr = (r_state == ST_DMA) ? dma_src_next[RAM_AW-1:0]
                                            : i_address[RAM_AW-1:0];
    assign rom_raddr  = (r_state == ST_DMA) ? dma_src_next[ROM_AW-1:0]
                                            : i_address[ROM_AW-1:0];
    assign rom_we     = exec_fire && rom_we_item;

    mbdt_ram #(
        .WIDTH (8),
        .DEPTH (mbdt_pkg::RAM_DEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (wram_we),
        .i_waddr (wram_waddr),
        .i_wdata (wram_wdata),
        .i_re    (wram_re),
        .i_raddr (wram_raddr),
        .o_rdata (ram_q)
    );

    mbdt_ram #(
        .WIDTH (8),
        .DEPTH (mbdt_pkg::ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_waddr (r_item.address[ROM_AW-1:0]),
        .i_wdata (r_item.write_data),
        .i_re    (wram_re),
        .i_raddr (rom_raddr),
        .o_rdata (rom_q)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_exec_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_joy        <= 8'h00;
            r_div        <= 8'h00;
            r_tima       <= 8'h00;
            r_tma        <= 8'h00;
            r_if         <= 8'h00;
            r_wfwd_valid <= 1'b0;
            r_rfwd_valid <= 1'b0;
            r_dma_cnt    <= '0;
            r_dma_dv     <= 1'b0;
        end else begin
            // accept into the execute slot, drop it once it retires
            if (accept) begin
                r_exec_valid <= 1'b1;
            end else if (exec_fire) begin
                r_exec_valid <= 1'b0;
            end

            // output register: load on retire, drop once taken
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (exec_fire) begin
                r_joy        <= n_joy;
                r_div        <= n_div;
                r_tima       <= n_tima;
                r_tma        <= n_tma;
                r_if         <= n_if;
                r_wfwd_valid <= ram_we_item;
                r_rfwd_valid <= rom_we_item;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= RAM_AW'(r_clr + 1'b1);
                    if (r_clr == RAM_AW'(mbdt_pkg::RAM_DEPTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (exec_fire && exec_is_dma) begin
                        r_state   <= ST_DMA;
                        r_dma_cnt <= '0;
                        r_dma_dv  <= 1'b0;
                    end
                end
                ST_DMA: begin
                    // issue one source read a cycle; the write follows in the next cycle
                    if (dma_issue) begin
                        r_dma_cnt <= DMA_CW'(r_dma_cnt + 1'b1);
                        r_dma_dv  <= 1'b1;
                    end else begin
                        r_dma_cnt <= '0;
                        r_dma_dv  <= 1'b0;
                        r_state   <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{kind:          i_kind,
                        address:       i_address,
                        write_data:    i_write_data,
                        interrupt_bit: i_interrupt_bit,
                        dpad_lines:    i_dpad_lines,
                        button_lines:  i_button_lines};
        end
        if (exec_fire) begin
            r_out_rd    <= n_rd;
            r_out_if    <= n_if;
            r_wfwd_idx  <= r_item.address[RAM_AW-1:0];
            r_wfwd_data <= r_item.write_data;
            r_rfwd_idx  <= r_item.address[ROM_AW-1:0];
            r_rfwd_data <= r_item.write_data;
        end
        if (dma_issue) begin
            r_dma_src <= dma_src_next;
            r_dma_idx <= 8'(r_dma_cnt);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_out_rd;
    assign o_interrupt_flags = r_out_if;

endmodule

`default_nettype wire

// ----- rtl/mbdt_checker.sv -----
// Port-level assertions for the memory bus, bound to the top level.
`default_nettype none

module mbdt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [2:0]  i_kind,
    input wire logic [15:0] i_address,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_read_data,
    input wire logic [7:0]  o_interrupt_flags
);

    // the clearing sweep holds off requests straight after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request accepted during the clearing sweep");

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data) && $stable(o_interrupt_flags))
        else $error("stalled result changed");

    // a fresh result is preceded by an accepted transaction
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a transaction");

    // a DMA-register write holds the request side while the copy runs
    a_dma_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == mbdt_pkg::KIND_WRITE)
            && (i_address == mbdt_pkg::ADDR_DMA) |=> o_stall ##1 o_stall)
        else $error("transaction accepted during DMA");

endmodule

bind memory_bus_with_dma_timer_irq mbdt_checker u_mbdt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_kind            (i_kind),
    .i_address         (i_address),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_read_data       (o_read_data),
    .o_interrupt_flags (o_interrupt_flags)
);

`default_nettype wire

// ----- tb/mbdt_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the memory bus: mirrors ROM and RAM, predicts each result and compares.
module mbdt_scoreboard (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [2:0]  i_interrupt_bit,
    input  wire logic [7:0]  i_dpad_lines,
    input  wire logic [7:0]  i_button_lines,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_stall,
    input  wire logic [7:0]  i_read_data,
    input  wire logic [7:0]  i_interrupt_flags,
    output int               o_mismatch_count,
    output int               o_pending_results
);

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] interrupt_flags;
    } t_bus_result;

    logic [7:0]  ram_image [mbdt_pkg::RAM_DEPTH];
    logic [7:0]  rom_image [mbdt_pkg::ROM_DEPTH];
    t_bus_result bus_results_due [$];
    int          mismatches;

    function automatic int unsigned ram_slot(input logic [15:0] addr);
        logic [15:0] offset;
        offset = addr - mbdt_pkg::RAM_BASE;
        return offset % mbdt_pkg::RAM_DEPTH;
    endfunction

    // Byte seen on the bus, with the joypad lines merged in by the select bits
    function automatic logic [7:0] bus_fetch(input logic [15:0] addr, input logic [7:0] dpad,
                                             input logic [7:0] buttons);
        logic [7:0] joy;
        if (addr < mbdt_pkg::RAM_BASE)
            return rom_image[addr % mbdt_pkg::ROM_DEPTH];
        if (addr == mbdt_pkg::ADDR_JOYPAD) begin
            joy = ram_image[ram_slot(mbdt_pkg::ADDR_JOYPAD)];
            case (joy[5:4])
                mbdt_pkg::JOY_SEL_NONE:    return mbdt_pkg::JOY_IDLE_VALUE;
                mbdt_pkg::JOY_SEL_DPAD:    return joy | dpad;
                mbdt_pkg::JOY_SEL_BUTTONS: return joy | buttons;
                default:                   return joy;
            endcase
        end
        return ram_image[ram_slot(addr)];
    endfunction

    function automatic t_bus_result bus_step(input logic [2:0] kind, input logic [15:0] addr,
                                             input logic [7:0] data, input logic [2:0] bit_idx,
                                             input logic [7:0] dpad, input logic [7:0] buttons);
        t_bus_result res;
        logic [7:0]  tima;
        logic [15:0] src;
        int          step;
        int unsigned div_slot;
        int unsigned if_slot;
        int unsigned tima_slot;
        div_slot  = ram_slot(mbdt_pkg::ADDR_DIV);
        if_slot   = ram_slot(mbdt_pkg::ADDR_IF);
        tima_slot = ram_slot(mbdt_pkg::ADDR_TIMA);
        res.read_data = 8'h00;
        case (kind)
            mbdt_pkg::KIND_READ: res.read_data = bus_fetch(addr, dpad, buttons);
            mbdt_pkg::KIND_WRITE: begin
                if (addr >= mbdt_pkg::RAM_BASE) begin
                    if (addr == mbdt_pkg::ADDR_DMA) begin
                        src = {data, 8'h00};
                        for (step = 0; step < mbdt_pkg::DMA_LENGTH; step++)
                            ram_image[ram_slot(mbdt_pkg::OAM_BASE + 16'(step))] =
                                bus_fetch(src + 16'(step), dpad, buttons);
                    end else if (addr == mbdt_pkg::ADDR_DIV) begin
                        ram_image[div_slot] = 8'h00;
                    end else begin
                        ram_image[ram_slot(addr)] = data;
                    end
                end
            end
            mbdt_pkg::KIND_ROM_LOAD: begin
                if (addr < mbdt_pkg::RAM_BASE)
                    rom_image[addr % mbdt_pkg::ROM_DEPTH] = data;
            end
            mbdt_pkg::KIND_DIV_TICK: ram_image[div_slot] = ram_image[div_slot] + 8'd1;
            mbdt_pkg::KIND_TIMER_TICK: begin
                tima = ram_image[tima_slot];
                if (tima == mbdt_pkg::BYTE_MAX) begin
                    ram_image[if_slot] = ram_image[if_slot] | mbdt_pkg::IF_TIMER_MASK;
                    ram_image[tima_slot] = ram_image[ram_slot(mbdt_pkg::ADDR_TMA)];
                end else begin
                    ram_image[tima_slot] = tima + 8'd1;
                end
            end
            mbdt_pkg::KIND_IRQ_SET:
                ram_image[if_slot] = ram_image[if_slot] | (8'h01 << bit_idx);
            mbdt_pkg::KIND_IRQ_CLEAR:
                ram_image[if_slot] = ram_image[if_slot] & ~(8'h01 << bit_idx);
            default: ;
        endcase
        res.interrupt_flags = ram_image[if_slot];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bus_result want;
        int          slot;
        if (!i_rst_n) begin
            for (slot = 0; slot < mbdt_pkg::RAM_DEPTH; slot++)
                ram_image[slot] = 8'h00;
            bus_results_due.delete();
            mismatches = 0;
        end else begin
            if (i_req_valid === 1'b1 && i_req_stall === 1'b0)
                bus_results_due.push_back(bus_step(i_kind, i_address, i_write_data,
                                                   i_interrupt_bit, i_dpad_lines,
                                                   i_button_lines));
            if (i_rsp_valid === 1'b1 && i_rsp_stall === 1'b0) begin
                if (bus_results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: read_data %02h interrupt_flags %02h",
                                 i_read_data, i_interrupt_flags);
                    mismatches++;
                end else begin
                    want = bus_results_due.pop_front();
                    if (i_read_data !== want.read_data ||
                        i_interrupt_flags !== want.interrupt_flags) begin
                        if (mismatches < 10)
                            $display("mismatch: read_data exp %02h got %02h, %s %02h got %02h",
                                     want.read_data, i_read_data, "interrupt_flags exp",
                                     want.interrupt_flags, i_interrupt_flags);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_count  <= mismatches;
        o_pending_results <= bus_results_due.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives bus transactions into the block and gives the verdict.
module tb;

    // Several times the RAM clearing sweep after reset, the longest dead stretch
    localparam int IDLE_LIMIT      = 150000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 200;
    localparam int PHASE_TXNS      = 460;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  kind = mbdt_pkg::KIND_READ;
    logic [15:0] address = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic [2:0]  interrupt_bit = 3'd0;
    logic [7:0]  dpad_lines = 8'h00;
    logic [7:0]  button_lines = 8'h00;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [7:0]  read_data;
    logic [7:0]  interrupt_flags;

    int mismatch_count;
    int pending_results;

    // Stimulus-side bookkeeping: which ROM bytes and whole DMA pages hold loaded data
    bit          rom_loaded [mbdt_pkg::ROM_DEPTH];
    logic [15:0] rom_loaded_list [$];
    bit          rom_page_full [128];
    logic [7:0]  rom_pages [$];

    int req_idle_pct = 35;
    int rsp_idle_pct = 81;
    int txn_sent = 0;
    bit hold_off_req = 1'b0;
    int idle_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    memory_bus_with_dma_timer_irq dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_kind           (kind),
        .i_address        (address),
        .i_write_data     (write_data),
        .i_interrupt_bit  (interrupt_bit),
        .i_dpad_lines     (dpad_lines),
        .i_button_lines   (button_lines),
        .o_valid          (rsp_valid),
        .i_stall          (rsp_stall),
        .o_read_data      (read_data),
        .o_interrupt_flags(interrupt_flags)
    );

    mbdt_scoreboard u_scoreboard (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_stall      (req_stall),
        .i_kind           (kind),
        .i_address        (address),
        .i_write_data     (write_data),
        .i_interrupt_bit  (interrupt_bit),
        .i_dpad_lines     (dpad_lines),
        .i_button_lines   (button_lines),
        .i_rsp_valid      (rsp_valid),
        .i_rsp_stall      (rsp_stall),
        .i_read_data      (read_data),
        .i_interrupt_flags(interrupt_flags),
        .o_mismatch_count (mismatch_count),
        .o_pending_results(pending_results)
    );

    // Offer one transaction and hold it until accepted. Idle cycles go in front of it at
    // the sender's rate; valid is only lowered when a gap is actually taken, so a
    // back-to-back transaction never sees valid dropped and raised in the same step.
    task automatic send_txn(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
                            input logic [2:0] b);
        logic [15:0] addr;
        logic [7:0]  data;
        addr = a;
        data = d;
        // Keep reads away from ROM bytes never loaded, directly or through a DMA copy
        if (k == mbdt_pkg::KIND_READ && addr < mbdt_pkg::RAM_BASE
            && !rom_loaded[addr % mbdt_pkg::ROM_DEPTH])
            addr = addr | mbdt_pkg::RAM_BASE;
        if (k == mbdt_pkg::KIND_WRITE && addr == mbdt_pkg::ADDR_DMA && data < 8'h80
            && !rom_page_full[data[6:0]])
            data[7] = 1'b1;
        if (k == mbdt_pkg::KIND_ROM_LOAD && addr < mbdt_pkg::RAM_BASE) begin
            rom_loaded[addr % mbdt_pkg::ROM_DEPTH] = 1'b1;
            rom_loaded_list.push_back(addr);
        end
        while ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        kind          <= k;
        address       <= addr;
        write_data    <= data;
        interrupt_bit <= b;
        dpad_lines    <= 8'($urandom);
        button_lines  <= 8'($urandom);
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        txn_sent++;
    endtask

    // Mostly addresses that matter: special registers, OAM, and the two ends of RAM
    function automatic logic [15:0] pick_ram_addr();
        case ($urandom_range(4))
            0: begin
                case ($urandom_range(5))
                    0:       return mbdt_pkg::ADDR_JOYPAD;
                    1:       return mbdt_pkg::ADDR_DIV;
                    2:       return mbdt_pkg::ADDR_TIMA;
                    3:       return mbdt_pkg::ADDR_TMA;
                    4:       return mbdt_pkg::ADDR_IF;
                    default: return mbdt_pkg::ADDR_DMA;
                endcase
            end
            1:       return mbdt_pkg::OAM_BASE + 16'($urandom_range(mbdt_pkg::DMA_LENGTH - 1));
            2:       return mbdt_pkg::RAM_BASE + 16'($urandom_range(15));
            3:       return 16'hFFF0 + 16'($urandom_range(15));
            default: return {1'b1, 15'($urandom)};
        endcase
    endfunction

    // One phase of random traffic. Open with a well-formed ROM page fill and its DMA
    // copy, then mix short sequences that reach the timer, divider, joypad and DMA paths
    // with unshaped noise mixed in.
    task automatic random_traffic(input int count);
        int          stop_at;
        int          choice;
        int          reps;
        int          n;
        logic [15:0] a;
        logic [7:0]  page;
        stop_at = txn_sent + count;
        page = 8'($urandom_range(127));
        for (n = 0; n < mbdt_pkg::DMA_LENGTH; n++)
            send_txn(mbdt_pkg::KIND_ROM_LOAD, {page, 8'h00} + 16'(n), 8'($urandom),
                     3'($urandom));
        rom_page_full[page[6:0]] = 1'b1;
        rom_pages.push_back(page);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_DMA, page, 3'($urandom));
        send_txn(mbdt_pkg::KIND_READ,
                 mbdt_pkg::OAM_BASE + 16'($urandom_range(mbdt_pkg::DMA_LENGTH - 1)),
                 8'($urandom), 3'($urandom));
        while (txn_sent < stop_at) begin
            choice = $urandom_range(99);
            if (choice < 30) begin
                if (rom_loaded_list.size() > 0 && $urandom_range(2) == 0)
                    a = rom_loaded_list[$urandom_range(rom_loaded_list.size() - 1)];
                else
                    a = pick_ram_addr();
                send_txn(mbdt_pkg::KIND_READ, a, 8'($urandom), 3'($urandom));
            end else if (choice < 52) begin
                a = ($urandom_range(7) == 0) ? 16'($urandom) : pick_ram_addr();
                send_txn(mbdt_pkg::KIND_WRITE, a, 8'($urandom), 3'($urandom));
            end else if (choice < 60) begin
                send_txn(mbdt_pkg::KIND_ROM_LOAD, 16'($urandom), 8'($urandom), 3'($urandom));
            end else if (choice < 65) begin
                reps = $urandom_range(4, 1);
                for (n = 0; n < reps; n++)
                    send_txn(mbdt_pkg::KIND_DIV_TICK, 16'($urandom), 8'($urandom),
                             3'($urandom));
                if ($urandom_range(2) == 0)
                    send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_DIV, 8'($urandom),
                             3'($urandom));
                send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_DIV, 8'($urandom), 3'($urandom));
            end else if (choice < 74) begin
                // Park TIMA close to the top so that overflow and reload come often
                if ($urandom_range(1) == 0)
                    send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_TMA, 8'($urandom),
                             3'($urandom));
                send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_TIMA,
                         8'($urandom_range(255, 248)), 3'($urandom));
                reps = $urandom_range(10, 1);
                for (n = 0; n < reps; n++)
                    send_txn(mbdt_pkg::KIND_TIMER_TICK, 16'($urandom), 8'($urandom),
                             3'($urandom));
                send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_TIMA, 8'($urandom),
                         3'($urandom));
            end else if (choice < 82) begin
                send_txn(($urandom_range(1) == 0) ? mbdt_pkg::KIND_IRQ_SET
                                                  : mbdt_pkg::KIND_IRQ_CLEAR,
                         16'($urandom), 8'($urandom), 3'($urandom));
            end else if (choice < 85) begin
                if (rom_pages.size() > 0 && $urandom_range(2) == 0)
                    page = rom_pages[$urandom_range(rom_pages.size() - 1)];
                else
                    page = {1'b1, 7'($urandom)};
                send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_DMA, page, 3'($urandom));
                send_txn(mbdt_pkg::KIND_READ,
                         mbdt_pkg::OAM_BASE + 16'($urandom_range(mbdt_pkg::DMA_LENGTH - 1)),
                         8'($urandom), 3'($urandom));
            end else if (choice < 92) begin
                send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_JOYPAD, 8'($urandom),
                         3'($urandom));
                reps = $urandom_range(3, 1);
                for (n = 0; n < reps; n++)
                    send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_JOYPAD, 8'($urandom),
                             3'($urandom));
            end else begin
                send_txn(3'($urandom), 16'($urandom), 8'($urandom), 3'($urandom));
            end
        end
    endtask

    // Receiver: stall at its own rate, and once take a long hold-off so the block fills
    // up and has to stall its input while the sender keeps offering.
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
                hold_left--;
            end else begin
                rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
            end
        end
    end

    // Watchdog: restart on any accepted transaction or taken result, give up after a long dead stretch
    always @(posedge clk) begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the first idling mix
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::RAM_BASE, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_ROM_LOAD, 16'h0000, 8'hFF, 3'd0);
        send_txn(mbdt_pkg::KIND_ROM_LOAD, 16'h7FFF, 8'h00, 3'd7);
        // Load aimed above the ROM: drop it
        send_txn(mbdt_pkg::KIND_ROM_LOAD, 16'h8000, 8'h5A, 3'd0);
        // Write into ROM space: ignore it, the loaded byte must survive
        send_txn(mbdt_pkg::KIND_WRITE, 16'h0000, 8'h11, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, 16'h0000, 8'h00, 3'd0);
        // Joypad: no lines selected, d-pad, buttons, then both
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_JOYPAD, 8'hFF, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_JOYPAD, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_JOYPAD, 8'hEF, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_JOYPAD, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_JOYPAD, 8'hDF, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_JOYPAD, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_JOYPAD, 8'hCF, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_JOYPAD, 8'h00, 3'd0);
        // DIV counts, then a write clears it whatever the data
        send_txn(mbdt_pkg::KIND_DIV_TICK, 16'hFFFF, 8'hFF, 3'd7);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_DIV, 8'hA5, 3'd0);
        send_txn(mbdt_pkg::KIND_DIV_TICK, 16'h0000, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_DIV, 8'h00, 3'd0);
        // Timer overflow: reload from TMA and raise the timer flag
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_TMA, 8'hAB, 3'd0);
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_TIMA, 8'hFF, 3'd0);
        send_txn(mbdt_pkg::KIND_TIMER_TICK, 16'h0000, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::ADDR_TIMA, 8'h00, 3'd0);
        send_txn(mbdt_pkg::KIND_IRQ_CLEAR, 16'h0000, 8'h00, 3'd2);
        send_txn(mbdt_pkg::KIND_IRQ_SET, 16'h0000, 8'h00, 3'd7);
        // DMA from the top page, which runs through the joypad and timer registers
        send_txn(mbdt_pkg::KIND_WRITE, mbdt_pkg::ADDR_DMA, 8'hFF, 3'd0);
        send_txn(mbdt_pkg::KIND_READ, mbdt_pkg::OAM_BASE, 8'h00, 3'd0);
        send_txn(KIND_UNUSED, 16'hFFFF, 8'hFF, 3'd7);

        random_traffic(PHASE_TXNS);

        req_idle_pct = 81;
        rsp_idle_pct = 35;
        random_traffic(PHASE_TXNS);

        // Full rate on both sides, with the long receiver hold-off at the start
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_off_req = 1'b1;
        random_traffic(PHASE_TXNS);

        req_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mbdt_pkg.sv
rtl/mbdt_ram.sv
rtl/memory_bus_with_dma_timer_irq.sv
rtl/mbdt_checker.sv
tb/mbdt_checker.sv
tb/tb.sv
